// ===== design/jde_pkg.sv =====
// Shared types, constants and helper functions of the Julia distance estimator.
`timescale 1ns / 1ps
package jde_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ITER_BITS = 10;
	localparam int CONST_W   = 19;
	localparam int POINT_W   = 20;
	localparam int DIST_W    = 21;
	localparam int ORBIT_W   = 32;
	localparam int DER_W     = 48;

	localparam logic [DER_W-1:0]  ONE_FX      = DER_W'(1) << FRAC_BITS;
	localparam logic [DER_W-1:0]  DER_MAX     = {DER_W{1'b1}};
	localparam logic [63:0]       DIST_MAX    = 64'((64'(1) << DIST_W) - 64'(1));
	localparam logic [31:0]       LN_SCALE    = 32'd1339670012;
	localparam logic [31:0]       ESCAPE_R    = 32'(ONE_FX) << 2;
	localparam logic [63:0]       SQ_BIT_INIT = 64'h4000_0000_0000_0000;
	localparam logic [6:0]        STEPS_LOG   = 7'(FRAC_BITS);
	localparam logic [6:0]        STEPS_ORBIT = 7'd32;
	localparam logic [6:0]        STEPS_FULL  = 7'd64;

	localparam logic [1:0] REG_CONST_X = 2'd0;
	localparam logic [1:0] REG_CONST_Y = 2'd1;
	localparam logic [1:0] REG_CONST_Z = 2'd2;
	localparam logic [1:0] REG_LIMIT   = 2'd3;

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_SQX, S_SQY, S_SQZ, S_RAD_INIT, S_RAD_SQRT, S_ESC,
		S_DER_LO, S_DER_HI, S_DER_UPD, S_CNT2, S_RHO_INIT, S_RHO_SQRT, S_RHO_CHK,
		S_DM_INIT, S_DM_DIV, S_AXAY, S_EM_INIT, S_EM_DIV, S_XM, S_YM, S_NZ,
		S_LOG_NORM, S_LOG_SQ, S_LN, S_MR, S_FDIV_INIT, S_FDIV, S_SAT, S_ZERO, S_OUT
	} state_t;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		mag32 = v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sh0_7FFF_FFFF)
			sat32 = 32'sh7FFF_FFFF;
		else if (v < -66'sh0_8000_0000)
			sat32 = -32'sh8000_0000;
		else
			sat32 = 32'(v);
	endfunction

endpackage

// ===== design/julia3d_distance_estimator_core.sv =====
// Top level of the power-2 triplex Julia set distance estimator.
//
// The block takes one request of a 3D point (point_x, point_y, point_z, signed
// Q4.16) on a valid/ready channel and returns one distance (unsigned Q5.16)
// on a second valid/ready channel. The Julia constant and the iteration limit
// are to be written by the user through a plain write port only while the block
// is idle; the block itself does not enforce this. Each request is worked on
// alone by a small sequencer around one 32x32 multiplier, one bit-serial square
// root unit and one radix-2 divider. An orbit iteration is dominated by two
// 32-step roots and two 32-step divides. The final estimate after escape takes
// up to 13 normalizing shifts, 16 log squarings and a 64-step divide. An item
// that hits the limit skips the estimate and shows a zero distance. in_ready
// is high only while no request is in work. The result waits in its output
// register while out_ready is low, and no new request is taken until it
// leaves. Reset returns the sequencer to idle, sets the constant to zero and
// the iteration limit to 16.
`timescale 1ns / 1ps
module julia3d_distance_estimator_core
	import jde_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [POINT_W-1:0] point_x,
	input  logic signed [POINT_W-1:0] point_y,
	input  logic signed [POINT_W-1:0] point_z,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [DIST_W-1:0]         distance,
	input  logic                      write_enable,
	input  logic [1:0]                write_index,
	input  logic [CONST_W-1:0]        write_data
);

	state_t state_q, state_n;

	logic signed [CONST_W-1:0] cx_q, cy_q, cz_q;
	logic [ITER_BITS-1:0]      limit_q, cnt_q;
	logic [6:0]                step_q;

	logic signed [ORBIT_W-1:0] orbit_x_q, orbit_y_q, orbit_z_q;
	logic [63:0]               x2_q, y2_q, z2_q;
	logic [31:0]               radius_q, rho_q, dm_q, em_q, y_q, m_q;
	logic [DER_W-1:0]          der_q;
	logic [79:0]               prod_q;
	logic [48:0]               xm_q, ym_q;
	logic [4:0]                p_q;
	logic [FRAC_BITS-1:0]      frac_q;
	logic [DIST_W-1:0]         dist_q;

	logic [63:0] sq_v_q, sq_res_q, sq_bit_q;
	logic [63:0] sq_sum, sq_v_n, sq_res_n;
	logic        sq_ge;

	logic [DER_W-1:0] dv_rem_q, dv_d_q, dv_rem_n;
	logic [63:0]      dv_lo_q, dv_lo_n;
	logic [DER_W:0]   dv_t;
	logic             dv_ge;

	logic [31:0] ax, ay, az, mul_a, mul_b, log_v;
	logic [63:0] mul_p, s_xy, dn;
	logic [64:0] der_sh;
	logic [32:0] log_t;
	logic signed [65:0] nx_v, ny_v, nz_v, diff_v;
	logic        x_neg, y_neg, step_last;

	assign ax = mag32(orbit_x_q);
	assign ay = mag32(orbit_y_q);
	assign az = mag32(orbit_z_q);
	assign s_xy = x2_q + y2_q;
	assign dn = (x2_q >= y2_q) ? x2_q - y2_q : y2_q - x2_q;
	assign step_last = (step_q == 7'd1);

	always_comb begin
		case (state_q)
			S_SQX:    begin mul_a = ax; mul_b = ax; end
			S_SQY:    begin mul_a = ay; mul_b = ay; end
			S_SQZ:    begin mul_a = az; mul_b = az; end
			S_DER_LO: begin mul_a = der_q[31:0]; mul_b = radius_q; end
			S_DER_HI: begin mul_a = {16'b0, der_q[47:32]}; mul_b = radius_q; end
			S_AXAY:   begin mul_a = ax; mul_b = ay; end
			S_XM:     begin mul_a = az; mul_b = dm_q; end
			S_YM:     begin mul_a = az; mul_b = em_q; end
			S_LOG_SQ: begin mul_a = y_q; mul_b = y_q; end
			S_LN:     begin mul_a = log_v; mul_b = LN_SCALE; end
			S_MR:     begin mul_a = m_q; mul_b = radius_q; end
			default:  begin mul_a = '0; mul_b = '0; end
		endcase
	end
	assign mul_p = 64'(mul_a) * 64'(mul_b);

	assign sq_sum   = sq_res_q + sq_bit_q;
	assign sq_ge    = sq_v_q >= sq_sum;
	assign sq_v_n   = sq_ge ? sq_v_q - sq_sum : sq_v_q;
	assign sq_res_n = sq_ge ? (sq_res_q >> 1) + sq_bit_q : sq_res_q >> 1;

	assign dv_t     = {dv_rem_q, dv_lo_q[63]};
	assign dv_ge    = dv_t >= {1'b0, dv_d_q};
	assign dv_rem_n = dv_ge ? DER_W'(dv_t - {1'b0, dv_d_q}) : dv_t[DER_W-1:0];
	assign dv_lo_n  = {dv_lo_q[62:0], dv_ge};

	assign der_sh = prod_q[79:15];
	assign log_t  = mul_p[63:31];
	assign log_v  = ((32'(p_q) - 32'(FRAC_BITS)) << FRAC_BITS) | 32'(frac_q);

	assign x_neg  = orbit_z_q[31] != (x2_q < y2_q);
	assign y_neg  = orbit_z_q[31] != (orbit_x_q[31] != orbit_y_q[31]);
	assign nx_v   = (x_neg ? -$signed({17'b0, xm_q}) : $signed({17'b0, xm_q})) + 66'(cx_q);
	assign ny_v   = (y_neg ? -$signed({17'b0, ym_q}) : $signed({17'b0, ym_q})) + 66'(cy_q);
	assign diff_v = $signed({2'b0, z2_q}) - $signed({2'b0, s_xy});
	assign nz_v   = (diff_v >>> FRAC_BITS) + 66'(cz_q);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE:      if (in_valid) state_n = S_CHECK;
			S_CHECK:     state_n = (cnt_q >= limit_q) ? S_ZERO : S_SQX;
			S_SQX:       state_n = S_SQY;
			S_SQY:       state_n = S_SQZ;
			S_SQZ:       state_n = S_RAD_INIT;
			S_RAD_INIT:  state_n = S_RAD_SQRT;
			S_RAD_SQRT:  if (sq_bit_q[0]) state_n = S_ESC;
			S_ESC:       state_n = (radius_q > ESCAPE_R) ? S_LOG_NORM : S_DER_LO;
			S_DER_LO:    state_n = S_DER_HI;
			S_DER_HI:    state_n = S_DER_UPD;
			S_DER_UPD:   state_n = S_CNT2;
			S_CNT2:      state_n = (cnt_q >= limit_q) ? S_ZERO : S_RHO_INIT;
			S_RHO_INIT:  state_n = S_RHO_SQRT;
			S_RHO_SQRT:  if (sq_bit_q[0]) state_n = S_RHO_CHK;
			S_RHO_CHK:   state_n = (rho_q == '0) ? S_NZ : S_DM_INIT;
			S_DM_INIT:   state_n = S_DM_DIV;
			S_DM_DIV:    if (step_last) state_n = S_AXAY;
			S_AXAY:      state_n = S_EM_INIT;
			S_EM_INIT:   state_n = S_EM_DIV;
			S_EM_DIV:    if (step_last) state_n = S_XM;
			S_XM:        state_n = S_YM;
			S_YM:        state_n = S_NZ;
			S_NZ:        state_n = S_CHECK;
			S_LOG_NORM:  if (y_q[31]) state_n = S_LOG_SQ;
			S_LOG_SQ:    if (step_last) state_n = S_LN;
			S_LN:        state_n = S_MR;
			S_MR:        state_n = S_FDIV_INIT;
			S_FDIV_INIT: state_n = S_FDIV;
			S_FDIV:      if (step_last) state_n = S_SAT;
			S_SAT:       state_n = S_OUT;
			S_ZERO:      state_n = S_OUT;
			S_OUT:       if (out_ready) state_n = S_IDLE;
			default:     state_n = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == S_IDLE);
		out_valid = (state_q == S_OUT);
		distance  = dist_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			step_q  <= '0;
			cx_q    <= '0;
			cy_q    <= '0;
			cz_q    <= '0;
			limit_q <= ITER_BITS'(16);
		end else begin
			state_q <= state_n;
			if (state_q == S_IDLE && in_valid)
				cnt_q <= '0;
			else if (state_q == S_DER_UPD)
				cnt_q <= cnt_q + 1'b1;
			case (state_q)
				S_LOG_NORM:                    step_q <= STEPS_LOG;
				S_DM_INIT, S_EM_INIT:          step_q <= STEPS_ORBIT;
				S_FDIV_INIT:                   step_q <= STEPS_FULL;
				S_DM_DIV, S_EM_DIV, S_FDIV,
				S_LOG_SQ:                      step_q <= step_q - 1'b1;
				default:                       step_q <= step_q;
			endcase
			if (write_enable) begin
				unique case (write_index)
					REG_CONST_X: cx_q    <= write_data;
					REG_CONST_Y: cy_q    <= write_data;
					REG_CONST_Z: cz_q    <= write_data;
					REG_LIMIT:   limit_q <= write_data[ITER_BITS-1:0];
					default:     limit_q <= limit_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					orbit_x_q <= ORBIT_W'(point_x);
					orbit_y_q <= ORBIT_W'(point_y);
					orbit_z_q <= ORBIT_W'(point_z);
					der_q     <= ONE_FX;
				end
			end
			S_SQX: x2_q <= mul_p;
			S_SQY: y2_q <= mul_p;
			S_SQZ: z2_q <= mul_p;
			S_RAD_INIT: begin
				sq_v_q   <= x2_q + y2_q + z2_q;
				sq_res_q <= '0;
				sq_bit_q <= SQ_BIT_INIT;
			end
			S_RAD_SQRT, S_RHO_SQRT: begin
				sq_v_q   <= sq_v_n;
				sq_res_q <= sq_res_n;
				sq_bit_q <= sq_bit_q >> 2;
				if (sq_bit_q[0]) begin
					if (state_q == S_RAD_SQRT)
						radius_q <= sq_res_n[31:0];
					else
						rho_q <= sq_res_n[31:0];
				end
			end
			S_ESC: begin
				y_q    <= radius_q;
				p_q    <= 5'd31;
				frac_q <= '0;
			end
			S_DER_LO: prod_q <= 80'(mul_p);
			S_DER_HI: prod_q <= prod_q + {mul_p[47:0], 32'b0};
			S_DER_UPD: begin
				if (der_sh > 65'(DER_MAX - ONE_FX))
					der_q <= DER_MAX;
				else
					der_q <= der_sh[DER_W-1:0] + ONE_FX;
			end
			S_RHO_INIT: begin
				sq_v_q   <= s_xy;
				sq_res_q <= '0;
				sq_bit_q <= SQ_BIT_INIT;
			end
			S_RHO_CHK: begin
				xm_q <= '0;
				ym_q <= '0;
			end
			S_DM_INIT: begin
				dv_rem_q <= DER_W'(dn[63:32]);
				dv_lo_q  <= {dn[31:0], 32'b0};
				dv_d_q   <= DER_W'(rho_q);
			end
			S_EM_INIT: begin
				dv_rem_q <= DER_W'(prod_q[62:31]);
				dv_lo_q  <= {prod_q[30:0], 33'b0};
				dv_d_q   <= DER_W'(rho_q);
			end
			S_DM_DIV, S_EM_DIV, S_FDIV: begin
				dv_rem_q <= dv_rem_n;
				dv_lo_q  <= dv_lo_n;
				if (step_last && state_q == S_DM_DIV)
					dm_q <= dv_lo_n[31:0];
				if (step_last && state_q == S_EM_DIV)
					em_q <= dv_lo_n[31:0];
			end
			S_AXAY: prod_q <= 80'(mul_p);
			S_XM:   xm_q <= {mul_p[63:FRAC_BITS], 1'b0};
			S_YM:   ym_q <= {mul_p[63:FRAC_BITS], 1'b0};
			S_NZ: begin
				orbit_x_q <= sat32(nx_v);
				orbit_y_q <= sat32(ny_v);
				orbit_z_q <= sat32(nz_v);
			end
			S_LOG_NORM: begin
				if (!y_q[31]) begin
					y_q <= y_q << 1;
					p_q <= p_q - 1'b1;
				end
			end
			S_LOG_SQ: begin
				if (log_t[32])
					y_q <= log_t[32:1];
				else
					y_q <= log_t[31:0];
				frac_q <= {frac_q[FRAC_BITS-2:0], log_t[32]};
			end
			S_LN: m_q <= mul_p[63:32];
			S_MR: prod_q <= 80'(mul_p);
			S_FDIV_INIT: begin
				dv_rem_q <= '0;
				dv_lo_q  <= prod_q[63:0];
				dv_d_q   <= der_q;
			end
			S_SAT:  dist_q <= (dv_lo_q > DIST_MAX) ? DIST_MAX[DIST_W-1:0] : dv_lo_q[DIST_W-1:0];
			S_ZERO: dist_q <= '0;
			default: begin
			end
		endcase
	end

	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output handshakes open at once");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_CHECK && cnt_q == '0)
		else $error("accepted request did not start at the iteration check");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> cnt_q <= limit_q)
		else $error("iteration count passed the limit");

	a_der_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FDIV_INIT |-> der_q >= ONE_FX)
		else $error("derivative below one at the final divide");

endmodule

// ===== bench/julia3d_distance_estimator_core_tb.sv =====
// Self-checking testbench for the power-2 triplex Julia distance estimator core.
`timescale 1ns / 1ps
module julia3d_distance_estimator_core_tb
	import jde_pkg::*;
();

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic signed [POINT_W-1:0] point_x;
	logic signed [POINT_W-1:0] point_y;
	logic signed [POINT_W-1:0] point_z;
	logic                      out_valid;
	logic                      out_ready;
	logic [DIST_W-1:0]         distance;
	logic                      write_enable;
	logic [1:0]                write_index;
	logic [CONST_W-1:0]        write_data;

	julia3d_distance_estimator_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_ready(out_ready), .distance(distance),
		.write_enable(write_enable), .write_index(write_index), .write_data(write_data)
	);

	logic signed [CONST_W-1:0] julia_cx, julia_cy, julia_cz;
	logic [ITER_BITS-1:0]      iter_limit;
	logic [DIST_W-1:0]         pending_distances[$];
	int                        error_count;
	bit                        idle_enable;
	int                        long_hold;
	int                        stall_left;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic bit [63:0] int_sqrt(bit [63:0] v);
		bit [63:0] res = 0;
		bit [63:0] b = 64'h4000_0000_0000_0000;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic bit [63:0] log2_q16(bit [63:0] v);
		int p;
		bit [63:0] y;
		bit [63:0] frac;
		p = 63;
		while (p > 0 && v[p] == 1'b0)
			p--;
		y = (p >= 31) ? (v >> (p - 31)) : (v << (31 - p));
		frac = 0;
		for (int i = 1; i <= FRAC_BITS; i++) begin
			y = (y * y) >> 31;
			if (y >= 64'h1_0000_0000) begin
				y >>= 1;
				frac[FRAC_BITS-i] = 1'b1;
			end
		end
		return (64'(p - FRAC_BITS) << FRAC_BITS) | frac;
	endfunction

	function automatic bit [63:0] magnitude(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic bit [DIST_W-1:0] expected_distance(logic signed [POINT_W-1:0] px,
			logic signed [POINT_W-1:0] py, logic signed [POINT_W-1:0] pz);
		longint ox, oy, oz, nx, ny, nz;
		bit [63:0] ax, ay, az, rad, der, x2, y2, z2, s, rho, dn, dm, em, xm, ym, m, q;
		bit [127:0] prod;
		int unsigned cnt;
		ox = px;
		oy = py;
		oz = pz;
		der = 64'd65536;
		cnt = 0;
		forever begin
			if (cnt >= iter_limit)
				return '0;
			ax = magnitude(ox);
			ay = magnitude(oy);
			az = magnitude(oz);
			rad = int_sqrt(ax * ax + ay * ay + az * az);
			if (rad > 64'd262144)
				break;
			prod = 128'(der) * 128'(rad << 1);
			if (prod[127:80] != 0 || prod[79:16] > 64'h0000_FFFF_FFFF_FFFF - 64'd65536)
				der = 64'h0000_FFFF_FFFF_FFFF;
			else
				der = prod[79:16] + 64'd65536;
			cnt++;
			if (cnt >= iter_limit)
				return '0;
			x2 = ax * ax;
			y2 = ay * ay;
			z2 = az * az;
			s = x2 + y2;
			rho = int_sqrt(s);
			nx = 0;
			ny = 0;
			if (rho != 0) begin
				dn = (x2 >= y2) ? x2 - y2 : y2 - x2;
				dm = dn / rho;
				em = (64'd2 * ax * ay) / rho;
				xm = ((az * dm) >> FRAC_BITS) << 1;
				ym = ((az * em) >> FRAC_BITS) << 1;
				nx = ((oz < 0) != (x2 < y2)) ? -longint'(xm) : longint'(xm);
				ny = ((oz < 0) != ((ox < 0) != (oy < 0))) ? -longint'(ym) : longint'(ym);
			end
			if (z2 >= s)
				nz = longint'((z2 - s) >> FRAC_BITS);
			else
				nz = -longint'((s - z2 + 64'd65535) >> FRAC_BITS);
			ox = clamp32(nx + julia_cx);
			oy = clamp32(ny + julia_cy);
			oz = clamp32(nz + julia_cz);
		end
		prod = 128'(log2_q16(rad)) * 128'(LN_SCALE);
		m = prod[95:32];
		prod = 128'(m) * 128'(rad);
		if (der == 0 || prod[127:64] >= der)
			q = '1;
		else
			q = 64'(prod / 128'(der));
		return q > DIST_MAX ? '1 : q[DIST_W-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Result checker.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_distances.size() == 0) begin
				report_mismatch($sformatf("unexpected distance %0d", distance));
			end else begin
				if (distance !== pending_distances[0])
					report_mismatch($sformatf("distance %0d, expected %0d",
						distance, pending_distances[0]));
				void'(pending_distances.pop_front());
			end
		end
	end

	// Receiver with random stalls and an optional long hold-off.
	always @(posedge clk) begin
		if (long_hold > 0) begin
			long_hold--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_enable && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 7);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_point(input logic signed [POINT_W-1:0] px,
			input logic signed [POINT_W-1:0] py, input logic signed [POINT_W-1:0] pz);
		if (idle_enable && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 8)) @(posedge clk);
		@(posedge clk);
		in_valid <= 1'b1;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_distances.push_back(expected_distance(px, py, pz));
		in_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_distances.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CONST_W-1:0] data);
		@(posedge clk);
		write_enable <= 1'b1;
		write_index <= idx;
		write_data <= data;
		case (idx)
			REG_CONST_X: julia_cx = data;
			REG_CONST_Y: julia_cy = data;
			REG_CONST_Z: julia_cz = data;
			REG_LIMIT:   iter_limit = data[ITER_BITS-1:0];
		endcase
		@(posedge clk);
		write_enable <= 1'b0;
	endtask

	task automatic set_julia(input logic [CONST_W-1:0] x, input logic [CONST_W-1:0] y,
			input logic [CONST_W-1:0] z, input logic [CONST_W-1:0] lim);
		wait_idle();
		write_reg(REG_CONST_X, x);
		write_reg(REG_CONST_Y, y);
		write_reg(REG_CONST_Z, z);
		write_reg(REG_LIMIT, lim);
	endtask

	function automatic logic signed [POINT_W-1:0] random_coord();
		if ($urandom_range(0, 3) == 0)
			return POINT_W'($urandom());
		return POINT_W'($signed($urandom_range(0, 2 * 163840)) - 163840);
	endfunction

	task automatic test_reset_defaults();
		send_point(0, 0, 0);
		send_point(0, 0, 20'sh10000);
		send_point(0, 0, 20'sh30000);
		send_point(0, 0, -20'sh30000);
		send_point(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF);
		send_point(-20'sh80000, -20'sh80000, -20'sh80000);
		send_point(20'sh7FFFF, -20'sh80000, 0);
		send_point(20'sh08000, -20'sh0C000, 20'sh04000);
		send_point(20'sh40001, 0, 0);
		send_point(20'sh40000, 0, 0);
	endtask

	task automatic test_config_extremes();
		set_julia(19'h3FFFF, 19'h3FFFF, 19'h3FFFF, 10'd5);
		send_point(0, 0, 0);
		send_point(20'sh01000, 20'sh02000, -20'sh01000);
		set_julia(19'h40000, 19'h40000, 19'h40000, 10'd5);
		send_point(0, 0, 0);
		send_point(-20'sh08000, 20'sh08000, 20'sh08000);
		set_julia(19'h04000, -19'sh08000, 19'h02000, 10'd1);
		send_point(20'sh01000, 20'sh01000, 20'sh01000);
		send_point(20'sh7FFFF, 0, 0);
		set_julia(0, 0, 0, 10'd0);
		send_point(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF);
		send_point(0, 0, 0);
		set_julia(-19'sh0A000, 19'h08000, 19'h01000, 10'd1023);
		send_point(20'sh0C000, -20'sh04000, 20'sh02000);
		set_julia(0, 0, 0, 10'd1023);
		send_point(0, 0, 0);
	endtask

	task automatic test_random_points(input int count, input bit with_idle);
		idle_enable = with_idle;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				set_julia($urandom_range(0, 3) == 0 ? CONST_W'($urandom())
						: CONST_W'($signed($urandom_range(0, 131072)) - 65536),
					$urandom_range(0, 3) == 0 ? CONST_W'($urandom())
						: CONST_W'($signed($urandom_range(0, 131072)) - 65536),
					$urandom_range(0, 3) == 0 ? CONST_W'($urandom())
						: CONST_W'($signed($urandom_range(0, 131072)) - 65536),
					CONST_W'($urandom_range(1, 12)));
			send_point(random_coord(), random_coord(), random_coord());
		end
	endtask

	task automatic test_output_hold();
		wait_idle();
		long_hold = 1500;
		for (int i = 0; i < 4; i++)
			send_point(random_coord(), random_coord(), random_coord());
	endtask

	initial begin
		error_count = 0;
		idle_enable = 1'b0;
		long_hold = 0;
		stall_left = 0;
		julia_cx = 0;
		julia_cy = 0;
		julia_cz = 0;
		iter_limit = 16;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		point_x <= '0;
		point_y <= '0;
		point_z <= '0;
		out_ready <= 1'b0;
		write_enable <= 1'b0;
		write_index <= '0;
		write_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_config_extremes();
		test_random_points(480, 1'b1);
		test_output_hold();
		test_random_points(40, 1'b0);

		wait_idle();
		repeat (50) @(posedge clk);
		if (error_count == 0)
			$display("julia3d_distance_estimator_core_tb: clean");
		else
			$display("julia3d_distance_estimator_core_tb: errors");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("julia3d_distance_estimator_core_tb: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/jde_pkg.sv
design/julia3d_distance_estimator_core.sv
bench/julia3d_distance_estimator_core_tb.sv
